/* hdl/pgsf_pkg.sv */
// Package: word type, fixed-point constants, saturating helpers and sequencer states.
`timescale 1ns / 1ps
`default_nettype none
package pgsf_pkg;
	localparam int FRAC_BITS  = 16;
	localparam int WORD_WIDTH = 32;
	localparam int NUM_REGS   = 5;
	localparam int LANES      = 3;

	typedef logic signed [WORD_WIDTH-1:0] word_t;

	localparam word_t W_MAX   = {1'b0, {(WORD_WIDTH-1){1'b1}}};
	localparam word_t W_MIN   = {1'b1, {(WORD_WIDTH-1){1'b0}}};
	localparam word_t HALF    = word_t'(64'sd1 <<< (FRAC_BITS-1));
	localparam word_t QUARTER = word_t'(64'sd1 <<< (FRAC_BITS-2));
	localparam word_t THIRD   = word_t'(((64'sd1 <<< FRAC_BITS) + 64'sd1) / 64'sd3);

	typedef enum logic [2:0] {
		REG_COEF_A     = 3'd0,
		REG_COEF_B     = 3'd1,
		REG_ELASTIC_K  = 3'd2,
		REG_FLOW_ALIGN = 3'd3,
		REG_ACTIVITY   = 3'd4
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_S0, ST_S1, ST_S2, ST_S3, ST_S4, ST_S5, ST_S6, ST_S7,
		ST_S8, ST_S9, ST_S10, ST_S11, ST_S12, ST_S13, ST_S14,
		ST_R1, ST_R2, ST_R3, ST_R4, ST_R5, ST_R6,
		ST_R7, ST_R8, ST_R9, ST_R10, ST_R11, ST_R12
	} state_t;

	function automatic word_t sadd(input word_t a, input word_t b);
		logic signed [WORD_WIDTH:0] s;
		s = {a[WORD_WIDTH-1], a} + {b[WORD_WIDTH-1], b};
		if (s[WORD_WIDTH] != s[WORD_WIDTH-1])
			return s[WORD_WIDTH] ? W_MIN : W_MAX;
		return word_t'(s[WORD_WIDTH-1:0]);
	endfunction

	function automatic word_t sneg(input word_t a);
		return (a == W_MIN) ? W_MAX : -a;
	endfunction

	function automatic word_t ssub(input word_t a, input word_t b);
		return sadd(a, sneg(b));
	endfunction
endpackage
`default_nettype wire

/* hdl/pgsf_if.sv */
// Interfaces: row input channel and stress result channel.
`timescale 1ns / 1ps
`default_nettype none
interface pgsf_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  row;
	logic signed [31:0] polar;
	logic signed [31:0] grad0;
	logic signed [31:0] grad1;
	logic signed [31:0] grad2;
	logic signed [31:0] laplacian;
	logic [23:0] site_tag;
	modport source (output valid, row, polar, grad0, grad1, grad2, laplacian, site_tag,
		input ready);
	modport sink (input valid, row, polar, grad0, grad1, grad2, laplacian, site_tag,
		output ready);
endinterface

interface pgsf_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  out_row;
	logic signed [31:0] stress0;
	logic signed [31:0] stress1;
	logic signed [31:0] stress2;
	logic signed [31:0] mol_field;
	logic signed [31:0] energy_density;
	logic [23:0] out_tag;
	logic        last;
	modport source (output valid, out_row, stress0, stress1, stress2, mol_field,
		energy_density, out_tag, last, input ready);
	modport sink (input valid, out_row, stress0, stress1, stress2, mol_field,
		energy_density, out_tag, last, output ready);
endinterface
`default_nettype wire

/* hdl/pgsf_lane_mul.sv */
// Lane multiplier: registered magnitude product, round half away from zero, saturate.
`timescale 1ns / 1ps
`default_nettype none
module pgsf_lane_mul
	import pgsf_pkg::*;
(
	input  wire   clk,
	input  word_t op_a,
	input  word_t op_b,
	output word_t prod
);
	localparam int PW = 2*WORD_WIDTH;

	logic [WORD_WIDTH-1:0] mag_a, mag_b;
	logic [PW-1:0]         mag_s1;
	logic                  neg_s1;
	logic [PW:0]           rnd;
	logic [PW:0]           shf;

	assign mag_a = op_a[WORD_WIDTH-1] ? (~op_a + 1'b1) : op_a;
	assign mag_b = op_b[WORD_WIDTH-1] ? (~op_b + 1'b1) : op_b;

	always_ff @(posedge clk) begin
		mag_s1 <= PW'(mag_a) * PW'(mag_b);
		neg_s1 <= op_a[WORD_WIDTH-1] ^ op_b[WORD_WIDTH-1];
	end

	assign rnd = {1'b0, mag_s1} + (PW+1)'(HALF);
	assign shf = rnd >> FRAC_BITS;

	always_comb begin
		if (shf > (PW+1)'(W_MAX))
			prod = neg_s1 ? W_MIN : W_MAX;
		else if (neg_s1)
			prod = -word_t'(shf[WORD_WIDTH-1:0]);
		else
			prod = word_t'(shf[WORD_WIDTH-1:0]);
	end
endmodule
`default_nettype wire

/* hdl/polar_gel_stress_and_field_core.sv */
// Polar gel molecular field, negated stress and free energy: row store, sequencer, lanes.
// Rows 0 and 1 are stored in the accept cycle; a row 2 item starts the site sequence,
//   which yields one result per row, and output stalls hold the sequence back.
// A site is three input items; no new row is taken until its sequence is done: the dependent
//   multiply-add chain runs on three shared lane multipliers, one lane per stress column.
// Reset: arst_n clears sequencer state, output valid, config regs; row buffers are unset.
`timescale 1ns / 1ps
`default_nettype none
module polar_gel_stress_and_field_core
	import pgsf_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	pgsf_in_if.sink    in_ch,
	pgsf_out_if.source out_ch,
	input  wire        cfg_we,
	input  wire [2:0]  cfg_index,
	input  wire [31:0] cfg_data
);
	state_t state_q, state_d;

	word_t coef_a_q, coef_b_q, elastic_k_q, flow_align_q, activity_q;
	word_t p_q [LANES];
	word_t g_q [LANES][LANES];
	word_t l_q [LANES];
	logic [23:0] tag_q;

	word_t p2_q, bp2_q, ap2_q, bpp_q, fa_q, fq_q, dp1_q, pdoth_q, tpd_q, tp2_q, kd_q, fed_q;
	word_t ap_q [LANES];
	word_t kl_q [LANES];
	word_t h_q  [LANES];
	word_t pahb_q [LANES];
	word_t dif_q  [LANES];
	word_t sum_q  [LANES];
	word_t pp_q   [LANES];
	word_t anti_q [LANES];
	word_t sym_q  [LANES];
	word_t gs_q   [LANES];
	word_t ls_q   [LANES];
	word_t kg_q   [LANES];
	logic [1:0] a_q;

	word_t op_a [LANES];
	word_t op_b [LANES];
	word_t prod [LANES];
	word_t res  [LANES];

	logic       out_vld_q;
	logic [1:0] o_row_q;
	word_t      o_s_q [LANES];
	word_t      o_h_q, o_f_q;
	logic [23:0] o_tag_q;
	logic       o_last_q;

	logic in_hs, out_free;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_hs       = in_ch.valid && in_ch.ready;
	assign out_free    = !out_vld_q || out_ch.ready;

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		pgsf_lane_mul u_mul (.clk(clk), .op_a(op_a[i]), .op_b(op_b[i]), .prod(prod[i]));
		// merge of the negated stress terms for column i
		assign res[i] = sneg(ssub(ssub(ssub(anti_q[i], ls_q[i]), kg_q[i]), prod[i]));
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_hs && in_ch.row == 2'd2) state_d = ST_S0;
			ST_S0:   state_d = ST_S1;
			ST_S1:   state_d = ST_S2;
			ST_S2:   state_d = ST_S3;
			ST_S3:   state_d = ST_S4;
			ST_S4:   state_d = ST_S5;
			ST_S5:   state_d = ST_S6;
			ST_S6:   state_d = ST_S7;
			ST_S7:   state_d = ST_S8;
			ST_S8:   state_d = ST_S9;
			ST_S9:   state_d = ST_S10;
			ST_S10:  state_d = ST_S11;
			ST_S11:  state_d = ST_S12;
			ST_S12:  state_d = ST_S13;
			ST_S13:  state_d = ST_S14;
			ST_S14:  state_d = ST_R1;
			ST_R1:   state_d = ST_R2;
			ST_R2:   state_d = ST_R3;
			ST_R3:   state_d = ST_R4;
			ST_R4:   state_d = ST_R5;
			ST_R5:   state_d = ST_R6;
			ST_R6:   state_d = ST_R7;
			ST_R7:   state_d = ST_R8;
			ST_R8:   state_d = ST_R9;
			ST_R9:   state_d = ST_R10;
			ST_R10:  state_d = ST_R11;
			ST_R11:  state_d = ST_R12;
			ST_R12:  if (out_free) state_d = (a_q == 2'd2) ? ST_IDLE : ST_R1;
			default: state_d = ST_IDLE;
		endcase
	end

	// lane operands
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			op_a[i] = '0;
			op_b[i] = '0;
		end
		unique case (state_q)
			ST_S0: for (int i = 0; i < LANES; i++) begin
				op_a[i] = p_q[i]; op_b[i] = p_q[i];
			end
			ST_S1: for (int i = 0; i < LANES; i++) begin
				op_a[i] = coef_a_q; op_b[i] = p_q[i];
			end
			ST_S2: begin
				op_a[0] = coef_b_q;    op_b[0] = p2_q;
				op_a[1] = elastic_k_q; op_b[1] = l_q[0];
				op_a[2] = elastic_k_q; op_b[2] = l_q[1];
			end
			ST_S3: begin
				op_a[0] = elastic_k_q; op_b[0] = l_q[2];
				op_a[1] = coef_a_q;    op_b[1] = p2_q;
			end
			ST_S4: for (int i = 0; i < LANES; i++) begin
				op_a[i] = bp2_q; op_b[i] = p_q[i];
			end
			ST_S5: begin
				op_a[0] = bp2_q;   op_b[0] = p2_q;
				op_a[1] = HALF;    op_b[1] = ap2_q;
				op_a[2] = g_q[0][0]; op_b[2] = g_q[0][0];
			end
			ST_S6: for (int i = 0; i < LANES; i++) begin
				op_a[i] = p_q[i]; op_b[i] = h_q[i];
			end
			ST_S7: begin
				op_a[0] = QUARTER;   op_b[0] = bpp_q;
				op_a[1] = g_q[0][1]; op_b[1] = g_q[0][1];
				op_a[2] = g_q[0][2]; op_b[2] = g_q[0][2];
			end
			ST_S8: for (int i = 0; i < LANES; i++) begin
				op_a[i] = g_q[1][i]; op_b[i] = g_q[1][i];
			end
			ST_S9: for (int i = 0; i < LANES; i++) begin
				op_a[i] = g_q[2][i]; op_b[i] = g_q[2][i];
			end
			ST_S10: begin
				op_a[0] = THIRD; op_b[0] = pdoth_q;
				op_a[1] = THIRD; op_b[1] = p2_q;
			end
			ST_S11: begin
				op_a[0] = elastic_k_q; op_b[0] = dp1_q;
			end
			ST_S13: begin
				op_a[0] = HALF; op_b[0] = kd_q;
			end
			ST_R1: for (int i = 0; i < LANES; i++) begin
				op_a[i] = p_q[a_q]; op_b[i] = h_q[i];
			end
			ST_R2: for (int i = 0; i < LANES; i++) begin
				op_a[i] = p_q[i]; op_b[i] = h_q[a_q];
			end
			ST_R3: for (int i = 0; i < LANES; i++) begin
				op_a[i] = p_q[a_q]; op_b[i] = p_q[i];
			end
			ST_R4: for (int i = 0; i < LANES; i++) begin
				op_a[i] = HALF; op_b[i] = dif_q[i];
			end
			ST_R5: for (int i = 0; i < LANES; i++) begin
				op_a[i] = HALF; op_b[i] = sum_q[i];
			end
			ST_R6: for (int i = 0; i < LANES; i++) begin
				op_a[i] = g_q[a_q][0]; op_b[i] = g_q[i][0];
			end
			ST_R7: for (int i = 0; i < LANES; i++) begin
				op_a[i] = g_q[a_q][1]; op_b[i] = g_q[i][1];
			end
			ST_R8: for (int i = 0; i < LANES; i++) begin
				op_a[i] = g_q[a_q][2]; op_b[i] = g_q[i][2];
			end
			ST_R9: for (int i = 0; i < LANES; i++) begin
				op_a[i] = flow_align_q; op_b[i] = sym_q[i];
			end
			ST_R10: for (int i = 0; i < LANES; i++) begin
				op_a[i] = elastic_k_q; op_b[i] = gs_q[i];
			end
			// R12 repeats R11 so the zeta product holds through an output stall
			ST_R11, ST_R12: for (int i = 0; i < LANES; i++) begin
				op_a[i] = activity_q; op_b[i] = pp_q[i];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_vld_q    <= 1'b0;
			coef_a_q     <= '0;
			coef_b_q     <= '0;
			elastic_k_q  <= '0;
			flow_align_q <= '0;
			activity_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_R12 && out_free) out_vld_q <= 1'b1;
			else if (out_vld_q && out_ch.ready) out_vld_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_COEF_A:     coef_a_q     <= cfg_data;
					REG_COEF_B:     coef_b_q     <= cfg_data;
					REG_ELASTIC_K:  elastic_k_q  <= cfg_data;
					REG_FLOW_ALIGN: flow_align_q <= cfg_data;
					REG_ACTIVITY:   activity_q   <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_hs && in_ch.row != 2'd3) begin
				p_q[in_ch.row]    <= in_ch.polar;
				g_q[in_ch.row][0] <= in_ch.grad0;
				g_q[in_ch.row][1] <= in_ch.grad1;
				g_q[in_ch.row][2] <= in_ch.grad2;
				l_q[in_ch.row]    <= in_ch.laplacian;
				tag_q             <= in_ch.site_tag;
			end
			ST_S1: p2_q <= sadd(sadd(prod[0], prod[1]), prod[2]);
			ST_S2: for (int i = 0; i < LANES; i++) ap_q[i] <= prod[i];
			ST_S3: begin
				bp2_q   <= prod[0];
				kl_q[0] <= prod[1];
				kl_q[1] <= prod[2];
			end
			ST_S4: begin
				kl_q[2] <= prod[0];
				ap2_q   <= prod[1];
			end
			ST_S5: for (int i = 0; i < LANES; i++)
				h_q[i] <= sadd(sadd(sneg(ap_q[i]), sneg(prod[i])), kl_q[i]);
			ST_S6: begin
				bpp_q <= prod[0];
				fa_q  <= prod[1];
				dp1_q <= prod[2];
			end
			ST_S7: pdoth_q <= sadd(sadd(prod[0], prod[1]), prod[2]);
			ST_S8: begin
				fq_q  <= prod[0];
				dp1_q <= sadd(sadd(dp1_q, prod[1]), prod[2]);
			end
			ST_S9, ST_S10: dp1_q <= sadd(sadd(sadd(dp1_q, prod[0]), prod[1]), prod[2]);
			ST_S11: begin
				tpd_q <= prod[0];
				tp2_q <= prod[1];
			end
			ST_S12: kd_q <= prod[0];
			ST_S14: begin
				fed_q <= sadd(sadd(fa_q, fq_q), prod[0]);
				a_q   <= 2'd0;
			end
			ST_R2: for (int i = 0; i < LANES; i++) pahb_q[i] <= prod[i];
			ST_R3: for (int i = 0; i < LANES; i++) begin
				dif_q[i] <= ssub(pahb_q[i], prod[i]);
				sum_q[i] <= sadd(pahb_q[i], prod[i]);
			end
			ST_R4: for (int i = 0; i < LANES; i++)
				pp_q[i] <= (a_q == 2'(i)) ? ssub(prod[i], tp2_q) : prod[i];
			ST_R5: for (int i = 0; i < LANES; i++) anti_q[i] <= prod[i];
			ST_R6: for (int i = 0; i < LANES; i++)
				sym_q[i] <= (a_q == 2'(i)) ? ssub(prod[i], tpd_q) : prod[i];
			ST_R7: for (int i = 0; i < LANES; i++) gs_q[i] <= prod[i];
			ST_R8, ST_R9: for (int i = 0; i < LANES; i++) gs_q[i] <= sadd(gs_q[i], prod[i]);
			ST_R10: for (int i = 0; i < LANES; i++) ls_q[i] <= prod[i];
			ST_R11: for (int i = 0; i < LANES; i++) kg_q[i] <= prod[i];
			ST_R12: if (out_free) begin
				for (int i = 0; i < LANES; i++) o_s_q[i] <= res[i];
				o_row_q  <= a_q;
				o_h_q    <= h_q[a_q];
				o_f_q    <= fed_q;
				o_tag_q  <= tag_q;
				o_last_q <= (a_q == 2'd2);
				a_q      <= a_q + 2'd1;
			end
			default: ;
		endcase
	end

	assign out_ch.valid          = out_vld_q;
	assign out_ch.out_row        = o_row_q;
	assign out_ch.stress0        = o_s_q[0];
	assign out_ch.stress1        = o_s_q[1];
	assign out_ch.stress2        = o_s_q[2];
	assign out_ch.mol_field      = o_h_q;
	assign out_ch.energy_density = o_f_q;
	assign out_ch.out_tag        = o_tag_q;
	assign out_ch.last           = o_last_q;

`ifndef SYNTHESIS
	a_row2_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_hs && in_ch.row == 2'd2) |=> (state_q == ST_S0))
		else $error("row 2 item did not start the site sequence");
	a_result_from_merge: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> ($past(state_q) == ST_R12))
		else $error("result appeared outside the merge step");
	a_mid_site_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.ready && !out_ch.last) |-> (state_q != ST_IDLE))
		else $error("sequencer idle with site rows still pending");
	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.last == (out_ch.out_row == 2'd2)))
		else $error("last flag does not match row index");
`endif
endmodule
`default_nettype wire

/* sim/pgsf_field_scoreboard.sv */
// Scoreboard: stress, molecular field and energy predictor for polar gel sites.
`timescale 1ns / 1ps
package pgsf_field_sb_pkg;
	import pgsf_pkg::*;

	typedef struct packed {
		logic [1:0]  out_row;
		logic [31:0] stress0;
		logic [31:0] stress1;
		logic [31:0] stress2;
		logic [31:0] mol_field;
		logic [31:0] energy_density;
		logic [23:0] out_tag;
		logic        last;
	} stress_row_t;

	class site_stress_scoreboard;
		word_t polar_st[3];
		word_t grad_st[9];
		word_t lap_st[3];
		word_t coef[NUM_REGS];
		stress_row_t pending[$];
		int mismatches;
		int results_seen;
		int sites_done;

		function void clear();
			foreach (coef[i]) coef[i] = '0;
			foreach (polar_st[i]) polar_st[i] = '0;
			foreach (grad_st[i]) grad_st[i] = '0;
			foreach (lap_st[i]) lap_st[i] = '0;
		endfunction

		function void set_coef(reg_idx_t idx, logic [31:0] v);
			coef[idx] = word_t'(v);
		endfunction

		// rounded (ties away from zero) and saturated fixed-point product
		function word_t qmul(word_t a, word_t b);
			logic signed [2*WORD_WIDTH+1:0] p;
			logic [2*WORD_WIDTH+1:0] mag;
			logic neg;
			p = $signed(a) * $signed(b);
			neg = p < 0;
			mag = neg ? -p : p;
			mag = (mag + (1 << (FRAC_BITS - 1))) >> FRAC_BITS;
			if (!neg) return (mag > W_MAX) ? W_MAX : word_t'(mag);
			if (mag > {1'b0, W_MAX}) return W_MIN;
			return word_t'(-$signed(mag));
		endfunction

		function void note_row(logic [1:0] r, logic [31:0] p, logic [31:0] g0,
				logic [31:0] g1, logic [31:0] g2, logic [31:0] lp, logic [23:0] tag);
			word_t a_c, b_c, k_c, l_c, z_c, p2, pdoth, dp1, bp2, fed, t;
			word_t h[3];
			word_t pahb, pbha, anti, sym, pp, gsum, s;
			stress_row_t e;
			a_c = '0; b_c = '0; k_c = '0; l_c = '0; z_c = '0;
			p2 = '0; pdoth = '0; dp1 = '0;
			if (r == 2'd3) return;
			polar_st[r] = p;
			grad_st[r*3] = g0; grad_st[r*3+1] = g1; grad_st[r*3+2] = g2;
			lap_st[r] = lp;
			if (r != 2'd2) return;
			a_c = coef[REG_COEF_A]; b_c = coef[REG_COEF_B]; k_c = coef[REG_ELASTIC_K];
			l_c = coef[REG_FLOW_ALIGN]; z_c = coef[REG_ACTIVITY];
			for (int i = 0; i < 3; i++) p2 = sadd(p2, qmul(polar_st[i], polar_st[i]));
			bp2 = qmul(b_c, p2);
			for (int i = 0; i < 3; i++) begin
				t = sadd(sneg(qmul(a_c, polar_st[i])), sneg(qmul(bp2, polar_st[i])));
				h[i] = sadd(t, qmul(k_c, lap_st[i]));
				pdoth = sadd(pdoth, qmul(polar_st[i], h[i]));
			end
			for (int j = 0; j < 9; j++) dp1 = sadd(dp1, qmul(grad_st[j], grad_st[j]));
			fed = sadd(sadd(qmul(HALF, qmul(a_c, p2)), qmul(QUARTER, qmul(bp2, p2))),
				qmul(HALF, qmul(k_c, dp1)));
			for (int i = 0; i < 3; i++) begin
				word_t srow[3];
				for (int k = 0; k < 3; k++) begin
					pahb = qmul(polar_st[i], h[k]);
					pbha = qmul(polar_st[k], h[i]);
					anti = qmul(HALF, ssub(pahb, pbha));
					sym = qmul(HALF, sadd(pahb, pbha));
					pp = qmul(polar_st[i], polar_st[k]);
					gsum = '0;
					if (i == k) begin
						sym = ssub(sym, qmul(THIRD, pdoth));
						pp = ssub(pp, qmul(THIRD, p2));
					end
					for (int c = 0; c < 3; c++)
						gsum = sadd(gsum, qmul(grad_st[i*3+c], grad_st[k*3+c]));
					s = ssub(anti, qmul(l_c, sym));
					s = ssub(s, qmul(k_c, gsum));
					s = ssub(s, qmul(z_c, pp));
					srow[k] = sneg(s);
				end
				e.out_row = i[1:0];
				e.stress0 = srow[0]; e.stress1 = srow[1]; e.stress2 = srow[2];
				e.mol_field = h[i];
				e.energy_density = fed;
				e.out_tag = tag;
				e.last = (i == 2);
				pending.push_back(e);
			end
			sites_done++;
		endfunction

		function void check_result(stress_row_t got);
			stress_row_t exp_r;
			results_seen++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("ERROR: unexpected result %p", got);
				return;
			end
			exp_r = pending.pop_front();
			if (got !== exp_r) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result mismatch\n  expected %p\n  actual   %p", exp_r, got);
			end
		endfunction
	endclass
endpackage

/* sim/polar_gel_stress_and_field_core_test.sv */
// Testbench top: drives rows and coefficients into the polar gel core and checks results.
`timescale 1ns / 1ps
module polar_gel_stress_and_field_core_test;
	import pgsf_pkg::*;
	import pgsf_field_sb_pkg::*;

	localparam int WATCHDOG = 20000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;
	int send_idle_pct;
	int recv_idle_pct;
	int quiet_cycles;
	int rows_sent;
	bit timed_out;

	pgsf_in_if in_ch();
	pgsf_out_if out_ch();

	polar_gel_stress_and_field_core u_top (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	site_stress_scoreboard sb = new();

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver: random ready, checks on accepted results
	always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			stress_row_t got;
			got.out_row = out_ch.out_row;
			got.stress0 = out_ch.stress0;
			got.stress1 = out_ch.stress1;
			got.stress2 = out_ch.stress2;
			got.mol_field = out_ch.mol_field;
			got.energy_density = out_ch.energy_density;
			got.out_tag = out_ch.out_tag;
			got.last = out_ch.last;
			sb.check_result(got);
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG && !timed_out) begin
			timed_out = 1'b1;
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic write_coef(reg_idx_t idx, logic [31:0] v);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_coef(idx, v);
	endtask

	task automatic send_row(logic [1:0] r, logic [31:0] p, logic [31:0] g0, logic [31:0] g1,
			logic [31:0] g2, logic [31:0] lp, logic [23:0] tag);
		do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		in_ch.valid <= 1'b1; in_ch.row <= r; in_ch.polar <= p;
		in_ch.grad0 <= g0; in_ch.grad1 <= g1; in_ch.grad2 <= g2;
		in_ch.laplacian <= lp; in_ch.site_tag <= tag;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_row(r, p, g0, g1, g2, lp, tag);
		rows_sent++;
		@(negedge clk);
		in_ch.valid <= 1'b0;
	endtask

	// values mostly near unity so the physics shows, sometimes full range
	function automatic logic [31:0] rnd_val();
		case ($urandom_range(5))
			0: return $urandom();
			1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			default: return 32'($signed($urandom_range(262144)) - 131072);
		endcase
	endfunction

	task automatic send_site(logic [23:0] tag, bit full_range);
		for (int r = 0; r < 3; r++)
			send_row(r[1:0], full_range ? $urandom() : rnd_val(), rnd_val(), rnd_val(),
				rnd_val(), rnd_val(), tag);
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic set_all(logic [31:0] a, logic [31:0] b, logic [31:0] k,
			logic [31:0] l, logic [31:0] z);
		write_coef(REG_COEF_A, a); write_coef(REG_COEF_B, b);
		write_coef(REG_ELASTIC_K, k); write_coef(REG_FLOW_ALIGN, l);
		write_coef(REG_ACTIVITY, z);
	endtask

	initial begin
		arst_n = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		in_ch.valid = 1'b0; in_ch.row = '0; in_ch.polar = '0; in_ch.grad0 = '0;
		in_ch.grad1 = '0; in_ch.grad2 = '0; in_ch.laplacian = '0; in_ch.site_tag = '0;
		send_idle_pct = 0; recv_idle_pct = 0; rows_sent = 0;
		sb.clear();
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: reset coefficients, then typical, then extremes
		send_site(24'h000001, 1'b0);
		drain();
		set_all(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'hffff_0000, 32'h0002_0000);
		send_site(24'hffffff, 1'b0);
		send_row(2'd0, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h80000000, 24'h0);
		send_row(2'd1, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h0, 32'h7fffffff, 24'h0);
		send_row(2'd3, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), 24'h5);
		send_row(2'd2, 32'h0, 32'h1, 32'hffffffff, 32'h0, 32'h0, 24'h123456);
		// row 2 alone reuses stored rows 0 and 1
		send_row(2'd2, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 24'hAAAAAA);
		drain();
		set_all(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		send_site(24'h555555, 1'b1);
		drain();
		set_all(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
		send_site(24'h0f0f0f, 1'b1);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 78 : 0;
			recv_idle_pct = (ph == 0) ? 78 : (ph == 1) ? 21 : 0;
			set_all($urandom_range(3) == 0 ? $urandom() : 32'($signed($urandom_range(262144)) - 131072),
				32'($signed($urandom_range(131072)) - 65536),
				32'($signed($urandom_range(131072)) - 65536),
				$urandom(), 32'($signed($urandom_range(131072)) - 65536));
			for (int s = 0; s < 16; s++) begin
				if ($urandom_range(9) == 0)
					send_row(2'($urandom_range(3)), $urandom(), $urandom(), $urandom(),
						$urandom(), $urandom(), 24'($urandom()));
				else
					send_site(24'($urandom()), $urandom_range(7) == 0);
			end
			drain();
		end

		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("Covered %0d rows, %0d sites, %0d results checked across coefficient sets",
				rows_sent, sb.sites_done, sb.results_seen);
			$display("Simulation PASSED");
		end else begin
			$display("Covered %0d rows, %0d mismatches, %0d results left unmatched",
				rows_sent, sb.mismatches, sb.pending.size());
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule

/* sim.f */
hdl/pgsf_pkg.sv
hdl/pgsf_if.sv
hdl/pgsf_lane_mul.sv
hdl/polar_gel_stress_and_field_core.sv
sim/pgsf_field_scoreboard.sv
sim/polar_gel_stress_and_field_core_test.sv
